[hw/rtl/star_rotate_project_classify_assert.svh]
// assertion helpers used by the top-level rtl
`ifndef STAR_ROTATE_PROJECT_CLASSIFY_ASSERT_SVH
`define STAR_ROTATE_PROJECT_CLASSIFY_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SRPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/srpc_pkg.sv]
package srpc_pkg;

  localparam int POS_W   = 24;
  localparam int TRIG_W  = 16;
  localparam int ZOOM_W  = 16;
  localparam int ROTX_W  = 33;
  localparam int ROTZ_W  = 30;
  localparam int NUM_W   = 50;
  localparam int MAG_W   = 49;
  localparam int DEN_W   = 37;

  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 128;

  localparam logic signed [ROTZ_W-1:0] NEAR_LIMIT = 30'sd409;

  localparam logic [7:0] BRIGHT_HI  = 8'd200;
  localparam logic [7:0] BRIGHT_MID = 8'd150;
  localparam logic [7:0] BRIGHT_LO  = 8'd100;

  localparam logic [2:0] COLOR_NONE = 3'd0;
  localparam logic [2:0] COLOR_HI   = 3'd4;
  localparam logic [2:0] COLOR_MID  = 3'd1;
  localparam logic [2:0] COLOR_LO   = 3'd2;
  localparam logic [2:0] COLOR_DIM  = 3'd3;

  localparam logic [2:0] REG_YAW_COS   = 3'd0;
  localparam logic [2:0] REG_YAW_SIN   = 3'd1;
  localparam logic [2:0] REG_PITCH_COS = 3'd2;
  localparam logic [2:0] REG_PITCH_SIN = 3'd3;
  localparam logic [2:0] REG_ROLL_COS  = 3'd4;
  localparam logic [2:0] REG_ROLL_SIN  = 3'd5;
  localparam logic [2:0] REG_ZOOM      = 3'd6;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] TRIG_ZERO = 16'sd0;
  localparam logic [ZOOM_W-1:0]        ZOOM_ONE  = 16'd256;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] bright;
    logic       last;
  } side_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] yaw_cos;
    logic signed [TRIG_W-1:0] yaw_sin;
    logic signed [TRIG_W-1:0] pitch_cos;
    logic signed [TRIG_W-1:0] pitch_sin;
    logic signed [TRIG_W-1:0] roll_cos;
    logic signed [TRIG_W-1:0] roll_sin;
  } trig_t;

  typedef struct packed {
    logic signed [ROTX_W-1:0] x;
    logic signed [ROTX_W-1:0] y;
    logic signed [ROTZ_W-1:0] z;
  } rot_t;

endpackage

[hw/rtl/srpc_if.sv]
interface srpc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pos_x;
  logic [23:0] pos_y;
  logic [23:0] pos_z;
  logic [7:0]  glyph;
  logic [7:0]  brightness;
  logic        last_star;

  modport source (output valid, pos_x, pos_y, pos_z, glyph, brightness, last_star,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, glyph, brightness, last_star,
                output ready);
endinterface

interface srpc_out_if;
  logic        valid;
  logic        ready;
  logic        visible;
  logic [7:0]  column;
  logic [6:0]  row;
  logic [14:0] cell_index;
  logic [7:0]  glyph_out;
  logic [2:0]  color_band;
  logic        frame_end;

  modport source (output valid, visible, column, row, cell_index, glyph_out, color_band,
                  frame_end, input ready);
  modport sink (input valid, visible, column, row, cell_index, glyph_out, color_band,
                frame_end, output ready);
endinterface

[hw/rtl/srpc_rotate.sv]
module srpc_rotate (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  srpc_pkg::pos_t  in_pos,
  input  srpc_pkg::side_t in_side,
  input  srpc_pkg::trig_t trig,
  output logic            out_valid,
  input  logic            out_ready,
  output srpc_pkg::rot_t  out_rot,
  output srpc_pkg::side_t out_side
);
  import srpc_pkg::*;

  logic [3:0] v_r;
  logic [3:0] en;

  // yaw products
  logic signed [39:0] s1_xc_r, s1_zs_r, s1_xs_r, s1_zc_r;
  logic signed [POS_W-1:0] s1_y_r;
  side_t s1_side_r;
  // pitch products
  logic signed [42:0] s2_zc_r, s2_zs_r;
  logic signed [39:0] s2_ys_r, s2_yc_r;
  logic signed [26:0] s2_x_r;
  side_t s2_side_r;
  // roll products
  logic signed [42:0] s3_xc_r, s3_xs_r;
  logic signed [45:0] s3_ys_r, s3_yc_r;
  logic signed [ROTZ_W-1:0] s3_z_r;
  side_t s3_side_r;
  rot_t  s4_rot_r;
  side_t s4_side_r;

  logic signed [40:0] yaw_a, yaw_b;
  logic signed [26:0] x1, z1;
  logic signed [43:0] pit_a, pit_b;
  logic signed [29:0] z2, y2;
  logic signed [46:0] rol_a, rol_b;
  logic signed [42:0] m2_zc, m2_zs, m3_xc, m3_xs;
  logic signed [39:0] m1_xc, m1_zs, m1_xs, m1_zc, m2_ys, m2_yc;
  logic signed [45:0] m3_ys, m3_yc;

  always_comb begin
    en[3] = !v_r[3] || out_ready;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    m1_xc = in_pos.x * trig.yaw_cos;
    m1_zs = in_pos.z * trig.yaw_sin;
    m1_xs = in_pos.x * trig.yaw_sin;
    m1_zc = in_pos.z * trig.yaw_cos;

    yaw_a = 41'(s1_xc_r) - 41'(s1_zs_r);
    yaw_b = 41'(s1_xs_r) + 41'(s1_zc_r);
    x1    = yaw_a[40:14];
    z1    = yaw_b[40:14];
    m2_zc = z1 * trig.pitch_cos;
    m2_zs = z1 * trig.pitch_sin;
    m2_ys = s1_y_r * trig.pitch_sin;
    m2_yc = s1_y_r * trig.pitch_cos;

    pit_a = 44'(s2_zc_r) - 44'(s2_ys_r);
    pit_b = 44'(s2_zs_r) + 44'(s2_yc_r);
    z2    = pit_a[43:14];
    y2    = pit_b[43:14];
    m3_xc = s2_x_r * trig.roll_cos;
    m3_xs = s2_x_r * trig.roll_sin;
    m3_ys = y2 * trig.roll_sin;
    m3_yc = y2 * trig.roll_cos;

    rol_a = 47'(s3_xc_r) - 47'(s3_ys_r);
    rol_b = 47'(s3_xs_r) + 47'(s3_yc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_xc_r   <= m1_xc;
      s1_zs_r   <= m1_zs;
      s1_xs_r   <= m1_xs;
      s1_zc_r   <= m1_zc;
      s1_y_r    <= in_pos.y;
      s1_side_r <= in_side;
    end
    if (en[1]) begin
      s2_zc_r   <= m2_zc;
      s2_zs_r   <= m2_zs;
      s2_ys_r   <= m2_ys;
      s2_yc_r   <= m2_yc;
      s2_x_r    <= x1;
      s2_side_r <= s1_side_r;
    end
    if (en[2]) begin
      s3_xc_r   <= m3_xc;
      s3_xs_r   <= m3_xs;
      s3_ys_r   <= m3_ys;
      s3_yc_r   <= m3_yc;
      s3_z_r    <= z2;
      s3_side_r <= s2_side_r;
    end
    if (en[3]) begin
      s4_rot_r.x <= rol_a[46:14];
      s4_rot_r.y <= rol_b[46:14];
      s4_rot_r.z <= s3_z_r;
      s4_side_r  <= s3_side_r;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[3];
  assign out_rot   = s4_rot_r;
  assign out_side  = s4_side_r;

endmodule

[hw/rtl/srpc_project.sv]
module srpc_project #(
  parameter int QB = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  srpc_pkg::rot_t            in_rot,
  input  srpc_pkg::side_t           in_side,
  input  logic [15:0]               zoom,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0][QB-1:0]        out_mag,
  output logic [1:0]                out_neg,
  output logic [1:0]                out_ovf,
  output logic                      out_cull,
  output srpc_pkg::side_t           out_side
);
  import srpc_pkg::*;

  localparam int NS = QB + 2;
  localparam int CW = MAG_W + QB;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // numerator stage
  logic signed [NUM_W-1:0] num_r [2];
  logic [DEN_W-1:0]        den0_r;
  logic                    cull0_r;
  side_t                   side0_r;

  // magnitude stage at index 0, one quotient bit per later index
  logic [MAG_W-1:0] rem_r  [QB+1][2];
  logic [QB-1:0]    quo_r  [QB+1][2];
  logic             neg_r  [QB+1][2];
  logic             ovf_r  [QB+1][2];
  logic [DEN_W-1:0] den_r  [QB+1];
  logic             cull_r [QB+1];
  side_t            side_r [QB+1];

  logic signed [16:0]      zoom_s;
  logic signed [NUM_W-1:0] prod [2];
  logic signed [NUM_W-1:0] absv [2];

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    zoom_s  = {1'b0, zoom};
    prod[0] = in_rot.x * zoom_s;
    prod[1] = in_rot.y * zoom_s;
    for (int l = 0; l < 2; l++) begin
      absv[l] = num_r[l][NUM_W-1] ? -num_r[l] : num_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_r[0] <= prod[0];
      num_r[1] <= prod[1];
      den0_r   <= {in_rot.z[28:0], 8'b0};
      cull0_r  <= (in_rot.z <= NEAR_LIMIT);
      side0_r  <= in_side;
    end
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= absv[l][MAG_W-1:0];
        quo_r[0][l] <= '0;
        neg_r[0][l] <= num_r[l][NUM_W-1];
        ovf_r[0][l] <= (CW'(absv[l][MAG_W-1:0]) >= (CW'(den0_r) << QB));
      end
      den_r[0]  <= den0_r;
      cull_r[0] <= cull0_r;
      side_r[0] <= side0_r;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_bit
    logic [CW-1:0]    dsh;
    logic [1:0]       ge;
    logic [MAG_W-1:0] rem_nxt [2];
    logic [QB-1:0]    quo_nxt [2];

    always_comb begin
      dsh = CW'(den_r[j-1]) << (QB - j);
      for (int l = 0; l < 2; l++) begin
        ge[l]      = CW'(rem_r[j-1][l]) >= dsh;
        rem_nxt[l] = ge[l] ? rem_r[j-1][l] - dsh[MAG_W-1:0] : rem_r[j-1][l];
        quo_nxt[l] = quo_r[j-1][l];
        quo_nxt[l][QB-j] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[j][l] <= rem_nxt[l];
          quo_r[j][l] <= quo_nxt[l];
          neg_r[j][l] <= neg_r[j-1][l];
          ovf_r[j][l] <= ovf_r[j-1][l];
        end
        den_r[j]  <= den_r[j-1];
        cull_r[j] <= cull_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign in_ready   = en[0];
  assign out_valid  = v_r[NS-1];
  assign out_mag[0] = quo_r[QB][0];
  assign out_mag[1] = quo_r[QB][1];
  assign out_neg    = {neg_r[QB][1], neg_r[QB][0]};
  assign out_ovf    = {ovf_r[QB][1], ovf_r[QB][0]};
  assign out_cull   = cull_r[QB];
  assign out_side   = side_r[QB];

endmodule

[hw/rtl/srpc_classify.sv]
module srpc_classify #(
  parameter int SCREEN_WIDTH  = srpc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = srpc_pkg::SCREEN_HEIGHT_DEF,
  parameter int QB            = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0][QB-1:0] in_mag,
  input  logic [1:0]         in_neg,
  input  logic [1:0]         in_ovf,
  input  logic               in_cull,
  input  srpc_pkg::side_t    in_side,
  srpc_out_if.source         out_ch
);
  import srpc_pkg::*;

  localparam int SW = QB + 2;
  localparam logic signed [SW-1:0] CX = SW'(SCREEN_WIDTH / 2);
  localparam logic signed [SW-1:0] CY = SW'(SCREEN_HEIGHT / 2);
  localparam logic signed [SW-1:0] WL = SW'(SCREEN_WIDTH);
  localparam logic signed [SW-1:0] HL = SW'(SCREEN_HEIGHT);

  logic v_r;
  logic en;
  logic        vis_r;
  logic [7:0]  col_r;
  logic [6:0]  row_r;
  logic [14:0] cell_r;
  logic [7:0]  glyph_r;
  logic [2:0]  color_r;
  logic        last_r;

  logic signed [SW-1:0] qx, qy, sx, sy;
  logic [31:0] sxu, syu, cell_full;
  logic        vis;
  logic [2:0]  color;

  always_comb begin
    qx  = in_neg[0] ? -$signed({2'b00, in_mag[0]}) : $signed({2'b00, in_mag[0]});
    qy  = in_neg[1] ? -$signed({2'b00, in_mag[1]}) : $signed({2'b00, in_mag[1]});
    sx  = CX + qx;
    sy  = CY + qy;
    sxu = 32'(sx);
    syu = 32'(sy);
    cell_full = syu * 32'(SCREEN_WIDTH) + sxu;
    vis = !in_cull && !in_ovf[0] && !in_ovf[1] &&
          (sx >= 0) && (sx < WL) && (sy >= 0) && (sy < HL);
    priority if (in_side.bright > BRIGHT_HI) begin
      color = COLOR_HI;
    end else if (in_side.bright > BRIGHT_MID) begin
      color = COLOR_MID;
    end else if (in_side.bright > BRIGHT_LO) begin
      color = COLOR_LO;
    end else begin
      color = COLOR_DIM;
    end
  end

  assign en = !v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r   <= vis;
      col_r   <= vis ? sxu[7:0] : 8'd0;
      row_r   <= vis ? syu[6:0] : 7'd0;
      cell_r  <= vis ? cell_full[14:0] : 15'd0;
      glyph_r <= vis ? in_side.glyph : 8'd0;
      color_r <= vis ? color : COLOR_NONE;
      last_r  <= in_side.last;
    end
  end

  assign in_ready          = en;
  assign out_ch.valid      = v_r;
  assign out_ch.visible    = vis_r;
  assign out_ch.column     = col_r;
  assign out_ch.row        = row_r;
  assign out_ch.cell_index = cell_r;
  assign out_ch.glyph_out  = glyph_r;
  assign out_ch.color_band = color_r;
  assign out_ch.frame_end  = last_r;

endmodule

[hw/rtl/star_rotate_project_classify.sv]
// Star rotate, project and classify pipeline: one star beat in per cycle unless the output
// stalls, one result beat out per star, in order. A star is rotated by yaw, pitch and roll
// (one register stage of multiplies per axis plus a final add stage), multiplied by zoom,
// then divided by view z in a restoring divider that settles one quotient bit per stage,
// and classified in the output register, with QB = clog2(max(width, height) + 1) quotient
// bits. Sustained rate is one star per clock when the output is not stalled; ready backs up
// stage by stage, so bubbles are squeezed out during a stall.
// Configuration writes take effect at once and are meant for idle periods.
`include "star_rotate_project_classify_assert.svh"

module star_rotate_project_classify #(
  parameter int SCREEN_WIDTH  = srpc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = srpc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  srpc_in_if.sink     in_ch,
  srpc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import srpc_pkg::*;

  // quotient bits needed to tell on screen from off screen
  localparam int MAXWH = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QB    = $clog2(MAXWH + 1);

  // configuration registers
  trig_t       trig_r;
  logic [15:0] zoom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.yaw_cos   <= TRIG_ONE;
      trig_r.yaw_sin   <= TRIG_ZERO;
      trig_r.pitch_cos <= TRIG_ONE;
      trig_r.pitch_sin <= TRIG_ZERO;
      trig_r.roll_cos  <= TRIG_ONE;
      trig_r.roll_sin  <= TRIG_ZERO;
      zoom_r           <= ZOOM_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YAW_COS:   trig_r.yaw_cos   <= cfg_data;
        REG_YAW_SIN:   trig_r.yaw_sin   <= cfg_data;
        REG_PITCH_COS: trig_r.pitch_cos <= cfg_data;
        REG_PITCH_SIN: trig_r.pitch_sin <= cfg_data;
        REG_ROLL_COS:  trig_r.roll_cos  <= cfg_data;
        REG_ROLL_SIN:  trig_r.roll_sin  <= cfg_data;
        REG_ZOOM:      zoom_r           <= cfg_data;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // input beat unpacked into position and sideband
  pos_t  in_pos;
  side_t in_side;

  assign in_pos.x       = in_ch.pos_x;
  assign in_pos.y       = in_ch.pos_y;
  assign in_pos.z       = in_ch.pos_z;
  assign in_side.glyph  = in_ch.glyph;
  assign in_side.bright = in_ch.brightness;
  assign in_side.last   = in_ch.last_star;

  // rotation stages
  logic  rot_valid, rot_ready;
  rot_t  rot;
  side_t rot_side;

  srpc_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_pos    (in_pos),
    .in_side   (in_side),
    .trig      (trig_r),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_rot   (rot),
    .out_side  (rot_side)
  );

  // zoom multiply, near cull and bit-per-stage divide
  logic               prj_valid, prj_ready;
  logic [1:0][QB-1:0] prj_mag;
  logic [1:0]         prj_neg, prj_ovf;
  logic               prj_cull;
  side_t              prj_side;

  srpc_project #(
    .QB (QB)
  ) u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_rot    (rot),
    .in_side   (rot_side),
    .zoom      (zoom_r),
    .out_valid (prj_valid),
    .out_ready (prj_ready),
    .out_mag   (prj_mag),
    .out_neg   (prj_neg),
    .out_ovf   (prj_ovf),
    .out_cull  (prj_cull),
    .out_side  (prj_side)
  );

  // screen bounds, cell index, color band; holds the output register
  srpc_classify #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .QB            (QB)
  ) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (prj_valid),
    .in_ready (prj_ready),
    .in_mag   (prj_mag),
    .in_neg   (prj_neg),
    .in_ovf   (prj_ovf),
    .in_cull  (prj_cull),
    .in_side  (prj_side),
    .out_ch   (out_ch)
  );

  // checker terms on the result beat
  logic out_fields_clear, out_color_banded;

  assign out_fields_clear = out_ch.column == 8'd0 && out_ch.row == 7'd0 &&
                            out_ch.cell_index == 15'd0 && out_ch.glyph_out == 8'd0 &&
                            out_ch.color_band == COLOR_NONE;
  assign out_color_banded = out_ch.color_band == COLOR_HI || out_ch.color_band == COLOR_MID ||
                            out_ch.color_band == COLOR_LO || out_ch.color_band == COLOR_DIM;

  // hidden stars carry only frame_end
  `SRPC_ASSERT_IMP(a_hidden_zero, out_ch.valid && !out_ch.visible, out_fields_clear, "hidden beat carries nonzero fields")
  // visible stars always get a real color band
  `SRPC_ASSERT_IMP(a_visible_color, out_ch.valid && out_ch.visible, out_color_banded, "visible beat without color band")
  // zoom register follows its write
  `SRPC_ASSERT_NXT(a_zoom_write, cfg_we && cfg_index == REG_ZOOM, zoom_r == $past(cfg_data), "zoom write lost")

endmodule

[test/tb_srpc_if_note.sv]
// scoreboard for the star pipeline: predicts one result beat per star beat
class star_scoreboard;
  typedef struct packed {
    logic        visible;
    logic [7:0]  column;
    logic [6:0]  row;
    logic [14:0] cell_index;
    logic [7:0]  glyph_out;
    logic [2:0]  color_band;
    logic        frame_end;
  } star_result_t;

  logic signed [15:0] trig [6];
  logic [15:0]        zoom;
  star_result_t       pending [$];
  int                 mismatches;
  int                 checked;
  int                 shown;

  function new();
    reset_regs();
    mismatches = 0;
    checked = 0;
    shown = 0;
  endfunction

  function void reset_regs();
    trig[0] = 16'sd16384; trig[1] = 16'sd0;
    trig[2] = 16'sd16384; trig[3] = 16'sd0;
    trig[4] = 16'sd16384; trig[5] = 16'sd0;
    zoom = 16'd256;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    if (idx < 3'd6) trig[idx] = val;
    else if (idx == 3'd6) zoom = val;
  endfunction

  // rotation stage with floor rounding back to Q12.12
  function void turn(inout longint a, inout longint b, input longint c, input longint s);
    longint na, nb;
    na = (a * c - b * s) >>> 14;
    nb = (a * s + b * c) >>> 14;
    a = na;
    b = nb;
  endfunction

  function void note_star(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                          logic [7:0] glyph, logic [7:0] bright, logic last);
    longint vx, vy, vz, den, sx, sy;
    star_result_t r;
    vx = longint'($signed(px));
    vy = longint'($signed(py));
    vz = longint'($signed(pz));
    r = '0;
    r.frame_end = last;
    turn(vx, vz, trig[0], trig[1]);
    turn(vz, vy, trig[2], trig[3]);
    turn(vx, vy, trig[4], trig[5]);
    if (vz > 409) begin
      den = vz * 256;
      sx = 128 + (vx * longint'(zoom)) / den;
      sy = 64 + (vy * longint'(zoom)) / den;
      if (sx >= 0 && sx < 256 && sy >= 0 && sy < 128) begin
        r.visible = 1'b1;
        r.column = sx[7:0];
        r.row = sy[6:0];
        r.cell_index = 15'(sy * 256 + sx);
        r.glyph_out = glyph;
        if (bright > 8'd200) r.color_band = 3'd4;
        else if (bright > 8'd150) r.color_band = 3'd1;
        else if (bright > 8'd100) r.color_band = 3'd2;
        else r.color_band = 3'd3;
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(star_result_t got);
    star_result_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result beat %h", got);
      end
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (shown < 10) begin
        shown++;
        $display("result mismatch: vis %b/%b col %0d/%0d row %0d/%0d cell %0d/%0d",
                 want.visible, got.visible, want.column, got.column, want.row, got.row,
                 want.cell_index, got.cell_index);
        $display("  glyph %0d/%0d color %0d/%0d end %b/%b (expected/actual)",
                 want.glyph_out, got.glyph_out, want.color_band, got.color_band,
                 want.frame_end, got.frame_end);
      end
    end
  endfunction
endclass

[test/tb_star_rotate_project_classify.sv]
module tb_star_rotate_project_classify;
  timeunit 1ns;
  timeprecision 1ps;

  import srpc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  srpc_in_if in_ch();
  srpc_out_if out_ch();

  star_rotate_project_classify DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // idle and stall odds out of a hundred, changed per phase
  int send_gap = 0;
  int recv_stall = 0;
  star_scoreboard board = new();
  int sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.glyph = '0;
    in_ch.brightness = '0;
    in_ch.last_star = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stall, check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.visible, out_ch.column, out_ch.row, out_ch.cell_index,
                          out_ch.glyph_out, out_ch.color_band, out_ch.frame_end});
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  // one write, then idle so back to back writes never stack on one edge
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // send one star beat, holding valid until accepted
  task automatic send_star(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                           logic [7:0] g, logic [7:0] b, logic last);
    while ($urandom_range(99) < send_gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.glyph <= g;
    in_ch.brightness <= b;
    in_ch.last_star <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_star(px, py, pz, g, b, last);
    sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // random star: mostly near the view axis in front so many land on screen
  task automatic random_star();
    logic [23:0] px, py, pz;
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      pz = 24'($urandom_range(200000, 400));
      px = 24'(int'($urandom_range(2 * pz)) - int'(pz));
      py = 24'(int'($urandom_range(pz)) - int'(pz / 2));
    end else begin
      px = 24'($urandom);
      py = 24'($urandom);
      pz = 24'($urandom);
    end
    send_star(px, py, pz, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // trig register values, extremes included
  function automatic logic [15:0] rand_trig();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  int phase;
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity rotation, field extremes, cull edge, bands, zoom zero
    send_star(24'h000000, 24'h000000, 24'd409, 8'hff, 8'd255, 1'b0);
    send_star(24'h000000, 24'h000000, 24'd410, 8'h2a, 8'd201, 1'b1);
    send_star(24'h000000, 24'h000000, 24'd4096, 8'h00, 8'd200, 1'b0);
    send_star(24'd4096, 24'd4096, 24'd4096, 8'h55, 8'd151, 1'b0);
    send_star(24'h000000, 24'h000000, 24'd4096, 8'haa, 8'd150, 1'b0);
    send_star(24'h000000, 24'h000000, 24'd4096, 8'h01, 8'd101, 1'b0);
    send_star(24'h000000, 24'h000000, 24'd4096, 8'h02, 8'd100, 1'b0);
    send_star(24'h000000, 24'h000000, 24'd4096, 8'h03, 8'd0, 1'b1);
    send_star(24'h7fffff, 24'h7fffff, 24'h7fffff, 8'h80, 8'd250, 1'b0);
    send_star(24'h800000, 24'h800000, 24'h7fffff, 8'h7f, 8'd120, 1'b0);
    send_star(24'h800000, 24'h7fffff, 24'h800000, 8'h11, 8'd180, 1'b1);
    send_star(-24'd524288, 24'd262144, 24'd4096, 8'h22, 8'd90, 1'b0);
    send_star(24'd520000, -24'd261000, 24'd4096, 8'h33, 8'd222, 1'b0);
    go_idle();
    write_reg(REG_ZOOM, 16'd0);
    send_star(24'h7fffff, 24'h800000, 24'd4096, 8'h44, 8'd160, 1'b1);
    go_idle();
    write_reg(REG_ZOOM, 16'hffff);
    send_star(24'd1, 24'hffffff, 24'h7fffff, 8'h66, 8'd140, 1'b0);
    send_star(24'd4096, 24'd4096, 24'h7fffff, 8'h77, 8'd60, 1'b1);
    go_idle();
    write_reg(REG_YAW_COS, 16'h7fff);
    write_reg(REG_YAW_SIN, 16'h8000);
    write_reg(REG_PITCH_COS, -16'sd16384);
    write_reg(REG_PITCH_SIN, 16'sd16384);
    write_reg(REG_ROLL_COS, 16'd0);
    write_reg(REG_ROLL_SIN, -16'sd16384);
    send_star(24'd8192, -24'd4096, 24'd12288, 8'h88, 8'd210, 1'b0);
    send_star(24'h7fffff, 24'h800000, 24'h7fffff, 8'h99, 8'd10, 1'b1);
    go_idle();

    // random phases: each picks fresh registers and an idling mix
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_gap = 0; recv_stall = 0; end
        1: begin send_gap = 68; recv_stall = 0; end
        2: begin send_gap = 0; recv_stall = 68; end
        default: begin send_gap = 11; recv_stall = 11; end
      endcase
      if (phase == 0) begin
        write_reg(REG_YAW_COS, 16'sd16384); write_reg(REG_YAW_SIN, 16'd0);
        write_reg(REG_PITCH_COS, 16'sd16384); write_reg(REG_PITCH_SIN, 16'd0);
        write_reg(REG_ROLL_COS, 16'sd16384); write_reg(REG_ROLL_SIN, 16'd0);
        write_reg(REG_ZOOM, 16'd256);
      end else begin
        write_reg(REG_YAW_COS, rand_trig()); write_reg(REG_YAW_SIN, rand_trig());
        write_reg(REG_PITCH_COS, rand_trig()); write_reg(REG_PITCH_SIN, rand_trig());
        write_reg(REG_ROLL_COS, rand_trig()); write_reg(REG_ROLL_SIN, rand_trig());
        write_reg(REG_ZOOM, ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(2048)));
      end
      repeat (110) random_star();
      go_idle();
    end

    $display("covered %0d star beats over four directed and twelve random register sets",
             sent);
    $display("%0d result beats checked under mixed sender idling and receiver stalls",
             board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb_star_rotate_project_classify: done, clean");
    else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("tb_star_rotate_project_classify: done, errors");
    end
    $finish;
  end

  // watchdog well past the slowest legal run
  initial begin
    #3ms;
    $display("timeout");
    $display("tb_star_rotate_project_classify: done, errors");
    $finish;
  end
endmodule

[star_rotate_project_classify.f]
+incdir+hw/rtl
hw/rtl/srpc_pkg.sv
hw/rtl/srpc_if.sv
hw/rtl/srpc_rotate.sv
hw/rtl/srpc_project.sv
hw/rtl/srpc_classify.sv
hw/rtl/star_rotate_project_classify.sv
test/tb_srpc_if_note.sv
test/tb_star_rotate_project_classify.sv
